// ===== rtl/mppl_pkg.sv =====
// Shared types and constants for the multichannel peak-to-peak locator.
// No dependencies; every other file in rtl/ imports this package.
package mppl_pkg;

	localparam int NUM_CHANNELS    = 4;
	localparam int SAMPLE_BITS     = 12;
	localparam int CH_W            = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int THR_W           = 12;
	localparam int AMP_W           = 12;
	localparam int NUM_AMP_OUT     = 4;
	localparam int LED_STRIDE      = 4;
	localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(50);
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONES = '1;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [CH_W-1:0]        chan_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   frame_end;
	} in_item_t;

	typedef struct packed {
		logic [AMP_W-1:0] amplitude_ch0;
		logic [AMP_W-1:0] amplitude_ch1;
		logic [AMP_W-1:0] amplitude_ch2;
		logic [AMP_W-1:0] amplitude_ch3;
		logic [1:0]       loudest_channel;
		logic [1:0]       runner_up_channel;
		logic             source_active;
		logic [3:0]       led_index;
	} out_item_t;

	// Per-channel extremes of one finished frame
	typedef struct packed {
		logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] ch_max;
		logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] ch_min;
	} snap_t;

endpackage

// ===== rtl/mppl_front.sv =====
// Front end: channel counter and running min/max trackers per channel.
// Pushes a frame snapshot on frame end. Depends on mppl_pkg.
module mppl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  mppl_pkg::in_item_t item,
	output logic              snap_push,
	output mppl_pkg::snap_t   snap_data
);
	import mppl_pkg::*;

	chan_t   ch_q;
	sample_t max_q [NUM_CHANNELS];
	sample_t min_q [NUM_CHANNELS];
	sample_t max_nxt [NUM_CHANNELS];
	sample_t min_nxt [NUM_CHANNELS];

	always_comb begin
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			max_nxt[c] = max_q[c];
			min_nxt[c] = min_q[c];
			if (ch_q == CH_W'(c)) begin
				if (item.sample > max_q[c]) max_nxt[c] = item.sample;
				if (item.sample < min_q[c]) min_nxt[c] = item.sample;
			end
			snap_data.ch_max[c] = max_nxt[c];
			snap_data.ch_min[c] = min_nxt[c];
		end
	end

	assign snap_push = accept & item.frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				max_q[c] <= '0;
				min_q[c] <= SAMPLE_ONES;
			end
		end else if (accept) begin
			if (item.frame_end) begin
				// frame closed: trackers back to empty, next frame starts at channel 0
				ch_q <= '0;
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					max_q[c] <= '0;
					min_q[c] <= SAMPLE_ONES;
				end
			end else begin
				ch_q <= (ch_q == CH_W'(NUM_CHANNELS - 1)) ? '0 : ch_q + 1'b1;
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					max_q[c] <= max_nxt[c];
					min_q[c] <= min_nxt[c];
				end
			end
		end
	end

endmodule

// ===== rtl/mppl_snap_fifo.sv =====
// Two-entry queue of frame snapshots between front and back.
// Depends on mppl_pkg.
module mppl_snap_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mppl_pkg::snap_t wr_data,
	input  logic            pop,
	output mppl_pkg::snap_t rd_data,
	output logic            full,
	output logic            empty
);
	import mppl_pkg::*;

	snap_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/mppl_back.sv =====
// Back end: amplitudes per channel (stage 1), then top-two ranking and
// activity check into the result register. Depends on mppl_pkg.
module mppl_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 snap_avail,
	input  mppl_pkg::snap_t      snap_data,
	output logic                 snap_pop,
	input  logic [mppl_pkg::THR_W-1:0] threshold,
	input  logic                 pop,
	output logic                 empty,
	output mppl_pkg::out_item_t  result
);
	import mppl_pkg::*;

	sample_t   amp_s1 [NUM_CHANNELS];
	logic      valid_s1;
	out_item_t out_q;
	logic      out_v_q;

	logic      out_free;
	logic      load_s1;
	chan_t     best;
	chan_t     second;
	logic      have_second;
	logic      active;
	sample_t   amp_out [NUM_AMP_OUT];
	out_item_t res_nxt;

	assign out_free = !out_v_q || pop;
	assign load_s1  = !valid_s1 || out_free;
	assign snap_pop = snap_avail && load_s1;
	assign empty    = !out_v_q;
	assign result   = out_q;

	// Ranking: strict compares keep the lower index on ties
	always_comb begin
		best        = '0;
		second      = '0;
		have_second = 1'b0;
		for (int c = 1; c < NUM_CHANNELS; c++) begin
			if (amp_s1[c] > amp_s1[best]) best = CH_W'(c);
		end
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			if (CH_W'(c) != best) begin
				if (!have_second || amp_s1[c] > amp_s1[second]) begin
					second      = CH_W'(c);
					have_second = 1'b1;
				end
			end
		end
		active = (32'(amp_s1[best]) >= 32'(threshold)) ||
		         (32'(amp_s1[second]) >= 32'(threshold));
		for (int c = 0; c < NUM_AMP_OUT; c++) begin
			amp_out[c] = (c < NUM_CHANNELS) ? amp_s1[c % NUM_CHANNELS] : '0;
		end
		res_nxt.amplitude_ch0     = AMP_W'(amp_out[0]);
		res_nxt.amplitude_ch1     = AMP_W'(amp_out[1]);
		res_nxt.amplitude_ch2     = AMP_W'(amp_out[2]);
		res_nxt.amplitude_ch3     = AMP_W'(amp_out[3]);
		res_nxt.loudest_channel   = 2'(32'(best));
		res_nxt.runner_up_channel = 2'(32'(second));
		res_nxt.source_active     = active;
		res_nxt.led_index         = 4'(32'(best) * LED_STRIDE);
	end

	always_ff @(posedge clk) begin
		if (snap_pop) begin
			// channel with no samples still has max < min: report 0
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				amp_s1[c] <= (snap_data.ch_max[c] >= snap_data.ch_min[c]) ?
				             snap_data.ch_max[c] - snap_data.ch_min[c] : '0;
			end
		end
		if (valid_s1 && out_free) out_q <= res_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (load_s1)  valid_s1 <= snap_avail;
			if (out_free) out_v_q  <= valid_s1;
		end
	end

endmodule

// ===== rtl/multichannel_peak_to_peak_locator_unit.sv =====
// Multichannel peak-to-peak locator: top level, threshold register and wiring.
// Path: a frame-end sample's snapshot passes the snapshot queue, the stage-1 amplitudes, then the result register.
// Throughput: one sample per cycle; full rises only when both snapshot queue
// entries are taken and the result queue is stalled.
// Reset: threshold 50, trackers empty (max 0, min all ones), counter 0, queues empty.
// Depends on mppl_pkg, mppl_front, mppl_snap_fifo, mppl_back.
module multichannel_peak_to_peak_locator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  mppl_pkg::in_item_t            item,
	output logic                          empty,
	input  logic                          pop,
	output mppl_pkg::out_item_t           result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mppl_pkg::THR_W-1:0]    cfg_data
);
	import mppl_pkg::*;

	logic             [THR_W-1:0] threshold_q;
	logic             accept;
	logic             snap_push;
	snap_t            snap_wr;
	snap_t            snap_rd;
	logic             snap_pop;
	logic             snap_empty;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			threshold_q <= cfg_data;
		end
	end

	mppl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.snap_push (snap_push),
		.snap_data (snap_wr)
	);

	mppl_snap_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (snap_push),
		.wr_data (snap_wr),
		.pop     (snap_pop),
		.rd_data (snap_rd),
		.full    (full),
		.empty   (snap_empty)
	);

	mppl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_avail (!snap_empty),
		.snap_data  (snap_rd),
		.snap_pop   (snap_pop),
		.threshold  (threshold_q),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

endmodule
